[hdl/fpm_pkg.sv]
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types and constants of the frequency and phase meter.
// ----------------------------------------------------------------------------
package fpm_pkg;

  // Field widths.
  localparam int COUNT_BITS = 16;
  localparam int TPS_BITS   = 27;
  localparam int DEG_BITS   = 9;
  localparam int PROD_BITS  = COUNT_BITS + TPS_BITS;
  localparam int DIV_BITS   = TPS_BITS + DEG_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

  // Constants of the measurement.
  localparam logic [TPS_BITS-1:0] TPS_RESET  = TPS_BITS'(1000000);
  localparam logic [DEG_BITS-1:0] DEGREES    = DEG_BITS'(360);
  localparam logic [TPS_BITS-1:0] MAX_DEGREE = TPS_BITS'(359);

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Result kinds.
  localparam logic KIND_FREQ  = 1'b0;
  localparam logic KIND_PHASE = 1'b1;

  typedef struct packed {
    logic tick;
    logic ref_edge;
    logic shift_edge;
  } fpm_in_t;

  typedef struct packed {
    logic                result_kind;
    logic [TPS_BITS-1:0] value;
    logic                zero_period;
    logic                phase_clamped;
    logic                last;
  } fpm_out_t;

  // One classified input transaction waiting for the back end.
  typedef struct packed {
    logic                  do_phase;
    logic                  do_ref;
    logic [COUNT_BITS-1:0] count;
  } fpm_job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PH_MUL,
    B_PH_CHECK,
    B_FR_START,
    B_DIV,
    B_EMIT
  } fpm_back_state_t;

endpackage

[hdl/fpm_front.sv]
// ----------------------------------------------------------------------------
// fpm_front
// Accepts input transactions, keeps the period counter and turns every
// transaction with an edge into a job for the back end.
// ----------------------------------------------------------------------------
module fpm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  fpm_pkg::fpm_in_t in_data,
  input  logic             queue_full,
  output logic             push,
  output fpm_pkg::fpm_job_t push_job
);
  import fpm_pkg::*;

  logic [COUNT_BITS-1:0] tick_count;
  logic [COUNT_BITS-1:0] count_after;
  logic                  accept;

  // Accept whenever the job queue has room.
  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  // The tick is counted before either edge is looked at.
  assign count_after = in_data.tick ? tick_count + COUNT_BITS'(1) : tick_count;

  // Only transactions carrying an edge produce work.
  assign push              = accept && (in_data.ref_edge || in_data.shift_edge);
  assign push_job.do_phase = in_data.shift_edge;
  assign push_job.do_ref   = in_data.ref_edge;
  assign push_job.count    = count_after;

  // A reference edge restarts the period.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (accept) begin
      tick_count <= in_data.ref_edge ? '0 : count_after;
    end
  end

endmodule

[hdl/fpm_queue.sv]
// ----------------------------------------------------------------------------
// fpm_queue
// Small first-in first-out buffer of jobs between front and back end.
// ----------------------------------------------------------------------------
module fpm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fpm_pkg::fpm_job_t push_job,
  input  logic              pop,
  output fpm_pkg::fpm_job_t head_job,
  output logic              full,
  output logic              empty
);
  import fpm_pkg::*;

  fpm_job_t               entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   fill;

  assign full     = (fill == QCNT_BITS'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign head_job = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_BITS'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_BITS'(1);
      end
    end
  end

endmodule

[hdl/fpm_div.sv]
// ----------------------------------------------------------------------------
// fpm_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fpm_pkg::DIV_BITS-1:0] dividend,
  input  logic [fpm_pkg::TPS_BITS-1:0] divisor,
  output logic                         done,
  output logic [fpm_pkg::DIV_BITS-1:0] quotient
);
  import fpm_pkg::*;

  logic [TPS_BITS-1:0]     rem;
  logic [TPS_BITS-1:0]     dsr;
  logic [DIV_CNT_BITS-1:0] steps;
  logic                    busy;
  logic [TPS_BITS:0]       trial;
  logic                    fits;

  // Bring down the next dividend bit and try to subtract.
  assign trial = {rem, quotient[DIV_BITS-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == DIV_CNT_BITS'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= DIV_CNT_BITS'(DIV_BITS);
      end else if (busy) begin
        steps <= steps - DIV_CNT_BITS'(1);
        busy  <= (steps != DIV_CNT_BITS'(1));
      end
    end
  end

  // Datapath: the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? TPS_BITS'(trial - {1'b0, dsr}) : trial[TPS_BITS-1:0];
      quotient <= {quotient[DIV_BITS-2:0], fits};
    end
  end

endmodule

[hdl/fpm_back.sv]
// ----------------------------------------------------------------------------
// fpm_back
// Takes jobs from the queue, computes phase and frequency with the shared
// divider and holds each result in the output register.
// ----------------------------------------------------------------------------
module fpm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [fpm_pkg::TPS_BITS-1:0] cfg_data,
  input  fpm_pkg::fpm_job_t            head_job,
  input  logic                         empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output fpm_pkg::fpm_out_t            out_data
);
  import fpm_pkg::*;

  fpm_back_state_t     state;
  fpm_back_state_t     state_next;
  fpm_job_t            job;
  logic                cur_kind;
  logic [TPS_BITS-1:0] tps;
  logic [TPS_BITS-1:0] last_freq;
  logic [PROD_BITS-1:0] prod;
  fpm_out_t            res;
  logic                clamp;
  logic                zero_count;
  logic                out_free;
  logic                out_load;
  logic                div_start;
  logic                div_done;
  logic [DIV_BITS-1:0] dividend;
  logic [TPS_BITS-1:0] divisor;
  logic [DIV_BITS-1:0] quotient;

  // Tick rate register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
    end else if (cfg_write) begin
      tps <= cfg_data;
    end
  end

  // A phase of 360 degrees or more is exactly a product at or above the rate.
  assign clamp      = (prod >= PROD_BITS'(tps));
  assign zero_count = (job.count == '0);
  assign out_free   = !out_valid || !out_stall;

  // Divider operands for the two kinds of job.
  always_comb begin
    if (state == B_PH_CHECK) begin
      dividend = DIV_BITS'(prod[TPS_BITS-1:0]) * DIV_BITS'(DEGREES);
      divisor  = tps;
    end else begin
      dividend = DIV_BITS'(tps);
      divisor  = TPS_BITS'(job.count);
    end
  end

  fpm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          state_next = head_job.do_phase ? B_PH_MUL : B_FR_START;
        end
      end
      B_PH_MUL: begin
        state_next = B_PH_CHECK;
      end
      B_PH_CHECK: begin
        state_next = clamp ? B_EMIT : B_DIV;
      end
      B_FR_START: begin
        state_next = zero_count ? B_EMIT : B_DIV;
      end
      B_DIV: begin
        if (div_done) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          state_next = (cur_kind == KIND_PHASE && job.do_ref) ? B_FR_START : B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Sequencer strobes.
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      B_IDLE:     pop       = !empty;
      B_PH_CHECK: div_start = !clamp;
      B_FR_START: div_start = !zero_count;
      B_EMIT:     out_load  = out_free;
      default: begin
        pop       = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Measurement state.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_freq <= '0;
    end else if (state == B_FR_START && zero_count) begin
      last_freq <= '0;
    end else if (state == B_DIV && div_done && cur_kind == KIND_FREQ) begin
      last_freq <= quotient[TPS_BITS-1:0];
    end
  end

  // Job data, product and pending result.
  always_ff @(posedge clk) begin
    if (pop) begin
      job      <= head_job;
      cur_kind <= head_job.do_phase ? KIND_PHASE : KIND_FREQ;
    end
    if (state == B_EMIT && out_free) begin
      cur_kind <= KIND_FREQ;
    end
    if (state == B_PH_MUL) begin
      prod <= PROD_BITS'(job.count) * PROD_BITS'(last_freq);
    end
    case (state)
      B_PH_CHECK: begin
        res.result_kind   <= KIND_PHASE;
        res.value         <= MAX_DEGREE;
        res.zero_period   <= 1'b0;
        res.phase_clamped <= 1'b1;
        res.last          <= !job.do_ref;
      end
      B_FR_START: begin
        res.result_kind   <= KIND_FREQ;
        res.value         <= '0;
        res.zero_period   <= 1'b1;
        res.phase_clamped <= 1'b0;
        res.last          <= 1'b1;
      end
      B_DIV: begin
        if (div_done) begin
          res.value         <= quotient[TPS_BITS-1:0];
          res.zero_period   <= 1'b0;
          res.phase_clamped <= 1'b0;
        end
      end
      default: begin
        res <= res;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  // A phase result never exceeds the largest whole degree.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_PHASE |-> out_data.value <= MAX_DEGREE)
    else $error("phase result above 359 degrees");

  // A zero period is reported only as a frequency of zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_period |->
      out_data.result_kind == KIND_FREQ && out_data.value == '0)
    else $error("zero period flag on a bad result");

  // Clamping belongs to phase results only.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.phase_clamped |-> out_data.result_kind == KIND_PHASE)
    else $error("clamp flag on a frequency result");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == B_DIV)
    else $error("divider finished outside the divide step");

  // A job is taken from the queue only when it holds one.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from an empty job queue");

endmodule

[hdl/frequency_phase_meter_core.sv]
// ----------------------------------------------------------------------------
// frequency_phase_meter_core
// Reciprocal frequency and phase meter with a decoupled job queue.
// ----------------------------------------------------------------------------
// Each input transaction may count one tick and report a reference and/or a
// shifted falling edge. The front end takes one transaction per cycle while
// its four-entry job queue has room; transactions without an edge produce
// nothing. Frequency and unclamped phase results come from one shared
// restoring divider that yields one quotient bit per cycle; a clamped phase
// or a zero period skips the divider. A transaction with both edges gives
// the phase result first. Results wait in an output register, and the tick
// rate register is written through cfg_write and cfg_data.
// ----------------------------------------------------------------------------
module frequency_phase_meter_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [fpm_pkg::TPS_BITS-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  fpm_pkg::fpm_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output fpm_pkg::fpm_out_t            out_data
);
  import fpm_pkg::*;

  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  fpm_job_t push_job;
  fpm_job_t head_job;

  // Counting and classification.
  fpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (full),
    .push       (push),
    .push_job   (push_job)
  );

  // Jobs waiting for the arithmetic.
  fpm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (full),
    .empty    (empty)
  );

  // Arithmetic and result delivery.
  fpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .head_job  (head_job),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
